### rtl/core/bfps_pkg.sv
// Package for the byte FIFO with pattern scan: transaction structs, codes, sizes.
// Depends on nothing; imported by byte_fifo_with_pattern_scan.
package bfps_pkg;

   localparam int DEPTH       = 16;
   localparam int MAX_PATTERN = 8;
   localparam int PTR_W       = $clog2(DEPTH);
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int FILL_W      = 5;
   localparam int THR_W       = 5;
   localparam int PAT_W       = 64;
   localparam int PAT_BYTES   = PAT_W / 8;
   localparam int J_W         = $clog2(PAT_BYTES);
   localparam int LEN_W       = 4;
   localparam int ADDR_W      = 5;
   localparam int DATA_W      = 64;

   typedef enum logic [1:0] {
      FUNC_WRITE = 2'd0,
      FUNC_READ  = 2'd1,
      FUNC_SCAN  = 2'd2,
      FUNC_NOP   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2,
      STATUS_RSVD  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      REG_THRESHOLD = 2'd0,
      REG_PATTERN   = 2'd1,
      REG_LENGTH    = 2'd2,
      REG_NONE      = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] data_in;
   } req_type;

   typedef struct packed {
      logic [7:0]        read_data;
      logic              found;
      logic              available;
      logic [FILL_W-1:0] fill_level;
      logic [1:0]        status;
   } rsp_type;

endpackage

### rtl/core/byte_fifo_with_pattern_scan.sv
// Top level of the byte FIFO with pattern scan: command channel, result strobe, APB registers.
// Depends on bfps_pkg.
//
//   channel   handshake                      payload
//   req       start in, busy out             req_data  (bfps_pkg::req_type)
//   rsp       rsp_valid out                  rsp_data  (bfps_pkg::rsp_type)
//   csr       psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// A write or a no-op finishes in the cycle it is accepted and its result appears the next cycle; busy stays low.
// A read of a held byte passes through ST_READ because the read data of the byte memory is
// registered; a read on empty finishes in the cycle it is accepted.
// A scan pops one byte per cycle until it finishes.
// Reset is synchronous and clears pointers, count, threshold and pattern, and sets the length to 1; no clearing pass.
// Each result shows for exactly one cycle; the receiver cannot stall it.
module byte_fifo_with_pattern_scan
   import bfps_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  req_type           req_data,
   output logic              rsp_valid,
   output rsp_type           rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   logic [7:0]       mem [DEPTH];
   logic [7:0]       mem_q_ff;

   state_type        state_ff, state_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [J_W-1:0]   j_ff, j_in;
   logic [THR_W-1:0] threshold_ff;
   logic [PAT_W-1:0] pattern_ff;
   logic [LEN_W-1:0] plen_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;

   logic             accept, empty, full, push, pop, finish;
   logic             res_found;
   status_type       res_status;
   logic [7:0]       res_rdata;
   logic [LEN_W-1:0] plen_eff;
   logic [7:0]       pat_byte;
   logic             byte_hit, last_match;
   logic             csr_write;
   reg_index_type    csr_index;

   assign pready    = 1'b1;
   assign csr_index = reg_index_type'(paddr[4:3]);
   assign csr_write = psel & penable & pwrite & pready;

   assign accept = start & (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);
   assign empty  = (count_ff == '0);
   assign full   = (count_ff == CNT_W'(DEPTH));

   always_comb begin
      if (plen_ff == '0) begin
         plen_eff = LEN_W'(1);
      end else if (plen_ff > LEN_W'(MAX_PATTERN)) begin
         plen_eff = LEN_W'(MAX_PATTERN);
      end else begin
         plen_eff = plen_ff;
      end
   end

   assign pat_byte   = pattern_ff[{j_ff, 3'b000} +: 8];
   assign byte_hit   = (mem_q_ff == pat_byte);
   assign last_match = ((LEN_W'(j_ff) + LEN_W'(1)) >= plen_eff);

   // outputs of the sequencer
   always_comb begin
      push       = 1'b0;
      pop        = 1'b0;
      finish     = 1'b0;
      res_found  = 1'b0;
      res_status = STATUS_OK;
      res_rdata  = '0;
      j_in       = j_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (func_type'(req_data.func))
                  FUNC_WRITE: begin
                     finish = 1'b1;
                     if (full) begin
                        res_status = STATUS_FULL;
                     end else begin
                        push = 1'b1;
                     end
                  end
                  FUNC_READ: begin
                     if (empty) begin
                        finish     = 1'b1;
                        res_status = STATUS_EMPTY;
                     end else begin
                        pop = 1'b1;
                     end
                  end
                  FUNC_SCAN: begin
                     j_in = '0;
                     if (empty) begin
                        finish = 1'b1;
                     end else begin
                        pop = 1'b1;
                     end
                  end
                  default: begin
                     finish = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            finish    = 1'b1;
            res_rdata = mem_q_ff;
         end
         ST_SCAN: begin
            if (byte_hit) begin
               if (last_match) begin
                  finish    = 1'b1;
                  res_found = 1'b1;
               end else if (empty) begin
                  finish = 1'b1;
               end else begin
                  pop  = 1'b1;
                  j_in = j_ff + J_W'(1);
               end
            end else if ((j_ff == '0) && !empty) begin
               pop = 1'b1;
            end else begin
               finish = 1'b1;
            end
         end
         default: begin
            finish = 1'b0;
         end
      endcase
   end

   // next state of the sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && pop) begin
               state_in = (func_type'(req_data.func) == FUNC_READ) ? ST_READ : ST_SCAN;
            end
         end
         ST_READ: begin
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in  = (tail_ff == PTR_W'(DEPTH - 1)) ? '0 : tail_ff + PTR_W'(1);
         count_in = count_ff + CNT_W'(1);
      end
      if (pop) begin
         head_in  = (head_ff == PTR_W'(DEPTH - 1)) ? '0 : head_ff + PTR_W'(1);
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[tail_ff] <= req_data.data_in;
      end
      if (pop) begin
         mem_q_ff <= mem[head_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         j_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         j_ff         <= j_in;
         rsp_valid_ff <= finish;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_data_ff.read_data  <= res_rdata;
         rsp_data_ff.found      <= res_found;
         rsp_data_ff.available  <= (count_in > CNT_W'(threshold_ff));
         rsp_data_ff.fill_level <= FILL_W'(count_in);
         rsp_data_ff.status     <= res_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
         pattern_ff   <= '0;
         plen_ff      <= LEN_W'(1);
      end else if (csr_write) begin
         unique case (csr_index)
            REG_THRESHOLD: threshold_ff <= pwdata[THR_W-1:0];
            REG_PATTERN:   pattern_ff   <= pwdata[PAT_W-1:0];
            REG_LENGTH:    plen_ff      <= pwdata[LEN_W-1:0];
            default:       plen_ff      <= plen_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_THRESHOLD: prdata = DATA_W'(threshold_ff);
         REG_PATTERN:   prdata = DATA_W'(pattern_ff);
         REG_LENGTH:    prdata = DATA_W'(plen_ff);
         default:       prdata = '0;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
